// ----- design/chme_pkg.sv -----
// Package: request kinds and response status codes of the chained hash map engine.
`default_nettype none
package chme_pkg;

   // Request kinds; codes above KIND_SCAN_NEXT are treated as unknown
   typedef enum logic [2:0] {
      KIND_INSERT    = 3'd0,
      KIND_FIND      = 3'd1,
      KIND_DELETE    = 3'd2,
      KIND_SCAN_START = 3'd3,
      KIND_SCAN_NEXT = 3'd4
   } kind_type;

   // Response status codes
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_NOT_FOUND = 3'd1,
      STATUS_POOL_FULL = 3'd2,
      STATUS_BAD_KEY   = 3'd3,
      STATUS_SCAN_END  = 3'd4
   } status_type;

   localparam int unsigned KEY_WIDTH = 64;
   localparam int unsigned WORD_WIDTH = 64;

endpackage
`default_nettype wire

// ----- design/chme_ifs.sv -----
// Interfaces: request and response channels of the chained hash map engine.
`default_nettype none
interface chme_req_if;
   logic                valid;
   logic                ready;
   chme_pkg::kind_type  kind;
   logic [63:0]         lookup_key;
   logic [63:0]         entry_value;

   modport source (output valid, kind, lookup_key, entry_value, input ready);
   modport sink   (input valid, kind, lookup_key, entry_value, output ready);
endinterface

interface chme_rsp_if;
   logic                 valid;
   logic                 ready;
   chme_pkg::status_type status;
   logic                 hit;
   logic [63:0]          entry_key_out;
   logic [63:0]          entry_value_out;

   modport source (output valid, status, hit, entry_key_out, entry_value_out, input ready);
   modport sink   (input valid, status, hit, entry_key_out, entry_value_out, output ready);
endinterface
`default_nettype wire

// ----- design/chme_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module chme_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- design/chained_hash_map_engine_unit.sv -----
// Top level: chained hash map engine, a sequencer around bucket-head and node memories.
// Insert hashes the key, reads the bucket head and links a new node in front; find/delete
//   walk the chain node by node, and delete then unlinks the node; bad key, pool full,
//   empty delete, scan start and unknown kind are answered from idle; scan next steps
//   along the current chain, then over the bucket heads. With a BUCKETS that is not a power
//   of two the bucket index is the reciprocal remainder of each key half, then of their combination.
// One request at a time: the next is taken once the response register is empty.
// Reset (synchronous) starts a clearing pass over every entry of the head memory;
//   no request is taken until it ends.
`default_nettype none
module chained_hash_map_engine_unit #(
   parameter int unsigned BUCKETS     = 256,
   parameter int unsigned POOL        = 256,
   parameter int unsigned VALUE_WIDTH = 64
) (
   input  wire logic   clock,
   input  wire logic   reset,
   chme_req_if.sink    req_if,
   chme_rsp_if.source  rsp_if
);
   localparam int unsigned KW  = chme_pkg::KEY_WIDTH;
   localparam int unsigned PW  = $clog2(POOL + 1);
   localparam int unsigned AW  = (POOL > 1) ? $clog2(POOL) : 1;
   localparam int unsigned HAW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned SW  = $clog2(BUCKETS + 1);
   localparam bit          POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
   localparam logic [PW-1:0] NIL = PW'(POOL);
   // reciprocal of the bucket count and 2^32 reduced by it
   localparam logic [31:0] MOD_RECIP = 32'(64'h1_0000_0000 / 64'(BUCKETS));
   localparam logic [31:0] MOD_R32   = 32'(64'h1_0000_0000 % 64'(BUCKETS));
   localparam logic [31:0] MOD_B32   = 32'(BUCKETS);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_HASH, ST_HEAD_RD, ST_HEAD_GOT, ST_WALK, ST_WALK_CHK,
      ST_DEL_W1, ST_DEL_W2, ST_SCN_RD, ST_SCN_LINK, ST_SCN_LOOP, ST_SCN_HEAD, ST_SCN_KV
   } state_type;

   state_type            state_ff;
   chme_pkg::kind_type   kind_ff;
   logic [KW-1:0]        key_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   logic [31:0]          mod_x_ff;
   logic [31:0]          mod_q_ff;
   logic [HAW-1:0]       mod_hi_ff;
   logic [HAW-1:0]       mod_lo_ff;
   logic [2:0]           mod_cnt_ff;
   logic [HAW-1:0]       bucket_ff;
   logic [HAW-1:0]       clr_ff;
   logic [PW-1:0]        free_head_ff;
   logic [PW-1:0]        fresh_count_ff;
   logic [PW-1:0]        key_count_ff;
   logic [SW-1:0]        scan_bucket_ff;
   logic [PW-1:0]        scan_node_ff;
   logic [PW-1:0]        cur_ff;
   logic [PW-1:0]        prev_ff;
   logic [PW-1:0]        nxt_ff;

   logic                 rsp_valid_ff;
   chme_pkg::status_type rsp_status_ff;
   logic                 rsp_hit_ff;
   logic [63:0]          rsp_key_ff;
   logic [63:0]          rsp_val_ff;

   // memory ports
   logic                       head_we;
   logic [HAW-1:0]             head_waddr, head_raddr;
   logic [PW-1:0]              head_wdata, head_rdata;
   logic                       kv_we;
   logic [AW-1:0]              node_waddr_kv, node_raddr;
   logic [KW+VALUE_WIDTH-1:0]  kv_wdata, kv_rdata;
   logic                       link_we;
   logic [AW-1:0]              link_waddr;
   logic [PW-1:0]              link_wdata, link_rdata;

   logic                  req_fire;
   logic                  free_ok;
   logic [PW-1:0]         new_node;
   logic [63:0]           mod_prod;
   logic [31:0]           mod_qb;
   logic [31:0]           mod_rest;
   logic [31:0]           mod_rem;
   logic [KW-1:0]         kv_key;
   logic [VALUE_WIDTH-1:0] kv_val;

   assign req_fire  = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign free_ok   = (free_head_ff < NIL);
   assign new_node  = free_ok ? free_head_ff : fresh_count_ff;
   assign kv_key    = kv_rdata[KW+VALUE_WIDTH-1:VALUE_WIDTH];
   assign kv_val    = kv_rdata[VALUE_WIDTH-1:0];

   // remainder step: quotient estimate is low by at most one, so one correction
   assign mod_prod = 64'(mod_x_ff) * 64'(MOD_RECIP);
   assign mod_qb   = mod_q_ff * MOD_B32;
   assign mod_rest = mod_x_ff - mod_qb;
   assign mod_rem  = (mod_rest >= MOD_B32) ? (mod_rest - MOD_B32) : mod_rest;

   // memory read addresses
   always_comb begin
      head_raddr = bucket_ff;
      node_raddr = cur_ff[AW-1:0];
      case (state_ff)
         ST_HEAD_RD:  node_raddr = free_head_ff[AW-1:0];
         ST_SCN_RD:   node_raddr = scan_node_ff[AW-1:0];
         ST_SCN_LOOP: begin
            node_raddr = scan_node_ff[AW-1:0];
            head_raddr = scan_bucket_ff[HAW-1:0];
         end
         default: ;
      endcase
   end

   // memory writes
   always_comb begin
      head_we       = 1'b0;
      head_waddr    = bucket_ff;
      head_wdata    = new_node;
      kv_we         = 1'b0;
      node_waddr_kv = new_node[AW-1:0];
      kv_wdata      = {key_ff, val_ff};
      link_we       = 1'b0;
      link_waddr    = new_node[AW-1:0];
      link_wdata    = head_rdata;
      case (state_ff)
         ST_CLEAR: begin
            head_we    = 1'b1;
            head_waddr = clr_ff;
            head_wdata = NIL;
         end
         ST_HEAD_GOT: begin
            if (kind_ff == chme_pkg::KIND_INSERT) begin
               head_we = 1'b1;
               kv_we   = 1'b1;
               link_we = 1'b1;
            end
         end
         ST_DEL_W1: begin
            if (prev_ff < NIL) begin
               link_we    = 1'b1;
               link_waddr = prev_ff[AW-1:0];
               link_wdata = nxt_ff;
            end else begin
               head_we    = 1'b1;
               head_wdata = nxt_ff;
            end
         end
         ST_DEL_W2: begin
            link_we    = 1'b1;
            link_waddr = cur_ff[AW-1:0];
            link_wdata = free_head_ff;
         end
         default: ;
      endcase
   end

   chme_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head_ram (
      .clock(clock), .wr_en(head_we), .wr_addr(head_waddr), .wr_data(head_wdata),
      .rd_addr(head_raddr), .rd_data(head_rdata)
   );

   chme_ram #(.WIDTH(KW + VALUE_WIDTH), .DEPTH(POOL)) u_kv_ram (
      .clock(clock), .wr_en(kv_we), .wr_addr(node_waddr_kv), .wr_data(kv_wdata),
      .rd_addr(node_raddr), .rd_data(kv_rdata)
   );

   chme_ram #(.WIDTH(PW), .DEPTH(POOL)) u_link_ram (
      .clock(clock), .wr_en(link_we), .wr_addr(link_waddr), .wr_data(link_wdata),
      .rd_addr(node_raddr), .rd_data(link_rdata)
   );

   // sequencer, map state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         free_head_ff   <= NIL;
         fresh_count_ff <= '0;
         key_count_ff   <= '0;
         scan_bucket_ff <= '0;
         scan_node_ff   <= NIL;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == HAW'(BUCKETS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  kind_ff       <= req_if.kind;
                  key_ff        <= req_if.lookup_key;
                  mod_x_ff      <= req_if.lookup_key[63:32];
                  val_ff        <= req_if.entry_value[VALUE_WIDTH-1:0];
                  mod_cnt_ff    <= '0;
                  rsp_status_ff <= chme_pkg::STATUS_OK;
                  rsp_hit_ff    <= 1'b0;
                  rsp_key_ff    <= '0;
                  rsp_val_ff    <= '0;
                  if (req_if.kind == chme_pkg::KIND_INSERT || req_if.kind == chme_pkg::KIND_FIND
                      || req_if.kind == chme_pkg::KIND_DELETE) begin
                     if (req_if.lookup_key == '0) begin
                        rsp_status_ff <= chme_pkg::STATUS_BAD_KEY;
                        rsp_valid_ff  <= 1'b1;
                     end else if (req_if.kind == chme_pkg::KIND_INSERT && !free_ok
                                  && fresh_count_ff == NIL) begin
                        rsp_status_ff <= chme_pkg::STATUS_POOL_FULL;
                        rsp_valid_ff  <= 1'b1;
                     end else if (req_if.kind == chme_pkg::KIND_DELETE
                                  && key_count_ff == '0) begin
                        rsp_status_ff <= chme_pkg::STATUS_NOT_FOUND;
                        rsp_valid_ff  <= 1'b1;
                     end else begin
                        state_ff <= ST_HASH;
                     end
                  end else if (req_if.kind == chme_pkg::KIND_SCAN_START) begin
                     scan_bucket_ff <= '0;
                     scan_node_ff   <= NIL;
                     rsp_valid_ff   <= 1'b1;
                  end else if (req_if.kind == chme_pkg::KIND_SCAN_NEXT) begin
                     state_ff <= (scan_node_ff < NIL) ? ST_SCN_RD : ST_SCN_LOOP;
                  end else begin
                     rsp_status_ff <= chme_pkg::STATUS_NOT_FOUND;
                     rsp_valid_ff  <= 1'b1;
                  end
               end
            end
            // bucket index: a mask for a power of two, else remainders of the key
            // halves, folded with 2^32 mod BUCKETS and reduced once more
            ST_HASH: begin
               if (POW2) begin
                  bucket_ff <= key_ff[HAW-1:0] & HAW'(BUCKETS - 1);
                  state_ff  <= ST_HEAD_RD;
               end else begin
                  mod_cnt_ff <= mod_cnt_ff + 1'b1;
                  case (mod_cnt_ff)
                     3'd1: begin
                        mod_hi_ff <= mod_rem[HAW-1:0];
                        mod_x_ff  <= key_ff[31:0];
                     end
                     3'd3: mod_lo_ff <= mod_rem[HAW-1:0];
                     3'd4: mod_x_ff  <= 32'(mod_hi_ff) * MOD_R32 + 32'(mod_lo_ff);
                     3'd6: begin
                        bucket_ff <= mod_rem[HAW-1:0];
                        state_ff  <= ST_HEAD_RD;
                     end
                     default: mod_q_ff <= mod_prod[63:32];
                  endcase
               end
            end
            ST_HEAD_RD: state_ff <= ST_HEAD_GOT;
            ST_HEAD_GOT: begin
               if (kind_ff == chme_pkg::KIND_INSERT) begin
                  if (free_ok) begin
                     free_head_ff <= link_rdata;
                  end else begin
                     fresh_count_ff <= fresh_count_ff + 1'b1;
                  end
                  key_count_ff <= key_count_ff + 1'b1;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  cur_ff   <= head_rdata;
                  prev_ff  <= NIL;
                  state_ff <= ST_WALK;
               end
            end
            // chain walk: read a node, compare, follow its link
            ST_WALK: begin
               if (cur_ff < NIL) begin
                  state_ff <= ST_WALK_CHK;
               end else begin
                  rsp_status_ff <= chme_pkg::STATUS_NOT_FOUND;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_WALK_CHK: begin
               if (kv_key == key_ff) begin
                  if (kind_ff == chme_pkg::KIND_FIND) begin
                     rsp_hit_ff   <= 1'b1;
                     rsp_key_ff   <= kv_key;
                     rsp_val_ff   <= 64'(kv_val);
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end else begin
                     nxt_ff   <= link_rdata;
                     state_ff <= ST_DEL_W1;
                  end
               end else begin
                  prev_ff  <= cur_ff;
                  cur_ff   <= link_rdata;
                  state_ff <= ST_WALK;
               end
            end
            ST_DEL_W1: state_ff <= ST_DEL_W2;
            ST_DEL_W2: begin
               free_head_ff <= cur_ff;
               key_count_ff <= key_count_ff - 1'b1;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            // scan: step along the current chain, then over bucket heads
            ST_SCN_RD:   state_ff <= ST_SCN_LINK;
            ST_SCN_LINK: begin
               scan_node_ff <= link_rdata;
               state_ff     <= ST_SCN_LOOP;
            end
            ST_SCN_LOOP: begin
               if (scan_node_ff < NIL) begin
                  state_ff <= ST_SCN_KV;
               end else if (scan_bucket_ff < SW'(BUCKETS)) begin
                  scan_bucket_ff <= scan_bucket_ff + 1'b1;
                  state_ff       <= ST_SCN_HEAD;
               end else begin
                  scan_node_ff  <= NIL;
                  rsp_status_ff <= chme_pkg::STATUS_SCAN_END;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_SCN_HEAD: begin
               scan_node_ff <= head_rdata;
               state_ff     <= ST_SCN_LOOP;
            end
            ST_SCN_KV: begin
               rsp_hit_ff   <= 1'b1;
               rsp_key_ff   <= kv_key;
               rsp_val_ff   <= 64'(kv_val);
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = rsp_status_ff;
   assign rsp_if.hit             = rsp_hit_ff;
   assign rsp_if.entry_key_out   = rsp_key_ff;
   assign rsp_if.entry_value_out = rsp_val_ff;

   // a response is only raised on the way back to idle or while idle
   a_rsp_in_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE)
      else $error("response pending while sequencer busy");

   // one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_if.ready)
      else $error("request taken while previous still open");

   // counts never pass the pool size
   a_counts: assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= NIL && fresh_count_ff <= NIL && key_count_ff <= fresh_count_ff)
      else $error("node counts out of range");

   // a delete step only follows a matching compare
   a_del_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DEL_W1 |-> $past(state_ff) == ST_WALK_CHK && kind_ff == chme_pkg::KIND_DELETE)
      else $error("unlink without a matching node");
endmodule
`default_nettype wire
